// File: src/hsbe_pkg.sv
// Shared types and constants of the hash set bucket engine.
package hsbe_pkg;

  localparam int unsigned KEY_W       = 31;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned BUCKET_W    = 6;
  // Request queue between front and back; depth must be a power of two.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Operation codes; code 3 is unused and handled as a miss.
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_DUP  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  // One classified request, bucket already resolved.
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [KEY_W-1:0]    key;
    logic [BUCKET_W-1:0] bucket;
  } req_t;

endpackage

// File: src/hsbe_ram.sv
// Generic single write port RAM with registered read.
module hsbe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: src/hsbe_front.sv
// Front end: accepts requests and resolves the bucket (key modulo bucket count).
module hsbe_front import hsbe_pkg::*; #(
  parameter int unsigned BUCKETS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [KEY_W-1:0]  key_i,
  output logic              full_o,
  input  logic [QCNT_W-1:0] q_count_i,
  output logic              q_push_o,
  output req_t              q_req_o
);

  // Byte weights 2^(8i) mod BUCKETS and the reciprocal for the final fold.
  localparam int unsigned W0         = 1 % BUCKETS;
  localparam int unsigned W1         = (1 << 8) % BUCKETS;
  localparam int unsigned W2         = (1 << 16) % BUCKETS;
  localparam int unsigned W3         = (1 << 24) % BUCKETS;
  localparam int unsigned FOLD_SHIFT = 22;
  localparam int unsigned RECIP      = (1 << FOLD_SHIFT) / BUCKETS;

  logic              accept;
  logic [QCNT_W:0]   load;
  logic [15:0]       sum_d;
  logic [39:0]       prod;
  logic [15:0]       quo_d;
  logic [15:0]       rem16;
  logic [6:0]        rem7;

  logic              v1_q, v2_q;
  req_t              req1_q, req2_q;
  logic [15:0]       sum1_q, sum2_q;
  logic [15:0]       quo2_q;

  // Credit check: queue words plus words in flight must fit the queue.
  assign load   = {1'b0, q_count_i} + {{QCNT_W{1'b0}}, v1_q} + {{QCNT_W{1'b0}}, v2_q};
  assign full_o = (load >= (QCNT_W + 1)'(QUEUE_DEPTH));
  assign accept = push_i && !full_o;

  // Stage 1: byte-weighted sum, congruent to the key, below 2^16.
  assign sum_d = 16'(key_i[7:0])   * 16'(W0)
               + 16'(key_i[15:8])  * 16'(W1)
               + 16'(key_i[23:16]) * 16'(W2)
               + 16'(key_i[30:24]) * 16'(W3);

  // Stage 2: quotient estimate, at most one below the true quotient.
  assign prod  = 40'(sum1_q) * 40'(RECIP);
  assign quo_d = 16'(prod >> FOLD_SHIFT);

  // Stage 3: remainder with one correction step.
  always_comb begin
    rem16 = sum2_q - 16'(quo2_q * 16'(BUCKETS));
    rem7  = 7'(rem16);
    if (rem7 >= 7'(BUCKETS)) begin
      rem7 = rem7 - 7'(BUCKETS);
    end
  end

  assign q_push_o       = v2_q;
  assign q_req_o.kind   = req2_q.kind;
  assign q_req_o.key    = req2_q.key;
  assign q_req_o.bucket = BUCKET_W'(rem7);

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    req1_q.kind   <= kind_i;
    req1_q.key    <= key_i;
    req1_q.bucket <= '0;
    sum1_q        <= sum_d;
    req2_q        <= req1_q;
    sum2_q        <= sum1_q;
    quo2_q        <= quo_d;
  end

  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load <= (QCNT_W + 1)'(QUEUE_DEPTH))
    else $error("front: words in flight exceed queue space");

endmodule

// File: src/hsbe_queue.sv
// Request queue between front and back.
module hsbe_queue import hsbe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  req_t              req_i,
  input  logic              pop_i,
  output req_t              req_o,
  output logic              empty_o,
  output logic [QCNT_W-1:0] count_o
);

  req_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign req_o   = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= req_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < QCNT_W'(QUEUE_DEPTH)) || pop_i)
    else $error("queue: push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue: pop while empty");

endmodule

// File: src/hsbe_back.sv
// Back end: reads a bucket row, compares all slots, writes back and holds the result.
module hsbe_back import hsbe_pkg::*; #(
  parameter int unsigned BUCKETS = 8,
  parameter int unsigned SLOTS   = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  req_t                q_req_i,
  output logic                q_pop_o,
  input  logic                res_pop_i,
  output logic                res_empty_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [BUCKET_W-1:0] bucket_o
);

  localparam int unsigned AW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned ROW_W = SLOTS * KEY_W;

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_LOOK = 2'b10
  } bk_state_e;

  bk_state_e           state_q, state_d;
  req_t                req_q;
  logic                start;
  logic [AW-1:0]       row;
  logic [ROW_W-1:0]    row_rd, row_wr;
  logic                row_we;
  logic [SLOTS-1:0]    valid_q [BUCKETS];
  logic [SLOTS-1:0]    valid_row, valid_nx, hit, free_oh;
  logic                valid_we;
  status_e             status;
  logic                res_valid_q;
  status_e             res_status_q;
  logic [BUCKET_W-1:0] res_bucket_q;

  // Start a lookup when a request waits and the result slot frees up.
  assign start   = (state_q == BK_IDLE) && !q_empty_i && (!res_valid_q || res_pop_i);
  assign q_pop_o = start;
  assign row     = req_q.bucket[AW-1:0];

  hsbe_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row),
    .wdata_i (row_wr),
    .re_i    (start),
    .raddr_i (q_req_i.bucket[AW-1:0]),
    .rdata_o (row_rd)
  );

  // Slot compare, free slot pick and outcome
  always_comb begin
    valid_row = valid_q[row];
    for (int s = 0; s < SLOTS; s++) begin
      hit[s] = valid_row[s] && (row_rd[s*KEY_W +: KEY_W] == req_q.key);
    end
    free_oh = ~valid_row & (valid_row + SLOTS'(1));
    for (int s = 0; s < SLOTS; s++) begin
      row_wr[s*KEY_W +: KEY_W] = free_oh[s] ? req_q.key : row_rd[s*KEY_W +: KEY_W];
    end
    status   = ST_MISS;
    valid_nx = valid_row;
    valid_we = 1'b0;
    unique case (req_q.kind)
      KIND_INSERT: begin
        if (|hit) begin
          status = ST_DUP;
        end else if (free_oh == '0) begin
          status = ST_FULL;
        end else begin
          status   = ST_DONE;
          valid_nx = valid_row | free_oh;
          valid_we = 1'b1;
        end
      end
      KIND_SEARCH: begin
        status = (|hit) ? ST_DONE : ST_MISS;
      end
      KIND_DELETE: begin
        if (|hit) begin
          status   = ST_DONE;
          valid_nx = valid_row & ~hit;
          valid_we = 1'b1;
        end
      end
      default: status = ST_MISS;
    endcase
  end

  assign row_we = (state_q == BK_LOOK) && valid_we && (req_q.kind == KIND_INSERT);

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (start) state_d = BK_LOOK;
      BK_LOOK: state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // Control state, valid marks and result occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      res_valid_q <= 1'b0;
      for (int b = 0; b < BUCKETS; b++) begin
        valid_q[b] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == BK_LOOK && valid_we) begin
        valid_q[row] <= valid_nx;
      end
      if (state_q == BK_LOOK) begin
        res_valid_q <= 1'b1;
      end else if (res_pop_i && res_valid_q) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (start) begin
      req_q <= q_req_i;
    end
    if (state_q == BK_LOOK) begin
      res_status_q <= status;
      res_bucket_q <= req_q.bucket;
    end
  end

  assign res_empty_o = !res_valid_q;
  assign status_o    = res_status_q;
  assign bucket_o    = res_bucket_q;

  a_res_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_LOOK |-> !res_valid_q)
    else $error("back: result overwritten before it was taken");

  a_hit_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_LOOK |-> $onehot0(hit))
    else $error("back: key present in more than one slot");

  a_res_posted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_LOOK |=> res_valid_q && state_q == BK_IDLE)
    else $error("back: lookup did not post a result");

endmodule

// File: src/hash_set_bucket_engine.sv
// Hash set bucket engine: top level joining front, request queue and back.
//
// A set of non-negative 31-bit keys held in BUCKETS buckets of SLOTS slots each; the bucket
// of a key is key modulo BUCKETS. Each request (insert, search, delete) yields one result
// word with a status and the bucket. Requests go through a three-stage front pipeline that
// works out the bucket, then a four-word queue, then the back end. The back end handles each
// request in two steps: it reads the bucket's key row from the row RAM, then compares all
// slots, writes the row back and posts the result. It takes a new request only after the
// last one has posted its result, and only while the result slot is empty or being popped.
// Slot valid marks are flip-flops cleared by reset, so the block takes requests right after
// reset with no clearing pass.
module hash_set_bucket_engine import hsbe_pkg::*; #(
  parameter int unsigned BUCKETS = 8,
  parameter int unsigned SLOTS   = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [KEY_W-1:0]    key_i,
  output logic                empty,
  input  logic                pop,
  output logic [STATUS_W-1:0] status_o,
  output logic [BUCKET_W-1:0] bucket_o
);

  logic              q_push, q_pop, q_empty;
  logic [QCNT_W-1:0] q_count;
  req_t              q_wr_req, q_rd_req;

  hsbe_front #(
    .BUCKETS (BUCKETS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .kind_i    (kind_i),
    .key_i     (key_i),
    .full_o    (full),
    .q_count_i (q_count),
    .q_push_o  (q_push),
    .q_req_o   (q_wr_req)
  );

  hsbe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .req_i   (q_wr_req),
    .pop_i   (q_pop),
    .req_o   (q_rd_req),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  hsbe_back #(
    .BUCKETS (BUCKETS),
    .SLOTS   (SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_req_i     (q_rd_req),
    .q_pop_o     (q_pop),
    .res_pop_i   (pop),
    .res_empty_o (empty),
    .status_o    (status_o),
    .bucket_o    (bucket_o)
  );

endmodule
